// ----- hdl/bpf_pkg.sv -----
// ---------------------------------------------------------------------------
// Bytecode peephole filter package
// Shared beat types, opcode classification and sizing constants.
// ---------------------------------------------------------------------------
package bpf_pkg;

   // Number of cascaded peephole passes (1..8).
   localparam int PASSES = 4;

   // Bound on a merged Pop run; the run count saturates at POP_CAP (1..255).
   localparam int MAX_POP_RUN = 255;
   localparam int POP_CAP = (MAX_POP_RUN < 1) ? 1 : ((MAX_POP_RUN > 255) ? 255 : MAX_POP_RUN);
   localparam logic [7:0] POP_CAP_B = POP_CAP[7:0];

   // Small queues between parts; depth is a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_POP_CODE         = 3'd0,
      CSR_DUP_CODE         = 3'd1,
      CSR_LOAD_LOCAL_CODE  = 3'd2,
      CSR_STORE_LOCAL_CODE = 3'd3,
      CSR_RETURN_CODE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] pop_code;
      logic [7:0] dup_code;
      logic [7:0] load_local_code;
      logic [7:0] store_local_code;
      logic [7:0] return_code;
   } csr_type;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] local_index;
      logic [31:0] payload;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_opcode;
      logic [15:0] out_index;
      logic [31:0] out_payload;
      logic [7:0]  repeat_res;
      logic        run_overflow;
      logic        out_last;
   } rsp_type;

   // Raw opcode matches; priority among them is applied by the pass logic.
   typedef struct packed {
      logic is_pop;
      logic is_dup;
      logic is_ld;
      logic is_st;
      logic is_ret;
   } cls_type;

   // One beat between the parts. live=0 is an end marker that only flushes.
   typedef struct packed {
      logic        live;
      logic [7:0]  opcode;
      logic [15:0] index;
      logic [31:0] payload;
      logic [7:0]  rep;
      logic        ovf;
      logic        last;
      cls_type     cls;
   } item_type;

   function automatic cls_type classify(input logic [7:0] op, input csr_type cfg);
      cls_type c;
      c.is_pop = (op == cfg.pop_code);
      c.is_dup = (op == cfg.dup_code);
      c.is_ld  = (op == cfg.load_local_code);
      c.is_st  = (op == cfg.store_local_code);
      c.is_ret = (op == cfg.return_code);
      return c;
   endfunction

endpackage

// ----- hdl/bytecode_peephole_filter.sv -----
// ---------------------------------------------------------------------------
// Bytecode peephole filter
// Reduces a stream of stack-machine instructions with cascaded peephole passes.
// ---------------------------------------------------------------------------
// The filter takes one instruction beat per cycle while full is low and, once the
// pipeline is primed and no result stalls, passes one beat per cycle through each
// of PASSES identical passes. A pass that must send out a held instruction and the
// new instruction that displaced it sends the held one first while the new beat
// waits, so a beat that expands into two results holds up that pass. A result can
// also wait while a pass holds a Dup, LdLoc or Pop run for the following
// instruction. A held instruction leaves only when the next one arrives or when
// its method ends, so mark the final instruction with last. Write the opcode
// registers only while the filter is idle.
// ---------------------------------------------------------------------------
module bytecode_peephole_filter (
   input  logic             clock,
   input  logic             reset,
   // instruction beats
   input  logic             push,
   input  bpf_pkg::req_type req_data,
   output logic             full,
   // result beats
   output logic             empty,
   input  logic             pop,
   output bpf_pkg::rsp_type rsp_data,
   // opcode registers
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_data
);
   import bpf_pkg::*;

   csr_type  csr_ff, csr_in;

   // front end to classify queue
   logic     fe_valid, fe_ready, q_full;
   item_type fe_item;

   // pass chain: position 0 is the classify queue head, PASSES is the last pass
   logic     chain_valid [PASSES+1];
   logic     chain_ready [PASSES+1];
   item_type chain_item  [PASSES+1];
   logic     q_empty;

   // result queue
   logic     rq_full, rq_push;
   item_type rq_head;

   // Take register writes every cycle; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_POP_CODE:         csr_in.pop_code         = csr_data;
            CSR_DUP_CODE:         csr_in.dup_code         = csr_data;
            CSR_LOAD_LOCAL_CODE:  csr_in.load_local_code  = csr_data;
            CSR_STORE_LOCAL_CODE: csr_in.store_local_code = csr_data;
            CSR_RETURN_CODE:      csr_in.return_code      = csr_data;
            default:              csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pop_code         <= 8'd0;
         csr_ff.dup_code         <= 8'd1;
         csr_ff.load_local_code  <= 8'd2;
         csr_ff.store_local_code <= 8'd3;
         csr_ff.return_code      <= 8'd4;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Accept and classify.
   bpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_cfg   (csr_ff),
      .req_push  (push),
      .req_data  (req_data),
      .req_full  (full),
      .out_valid (fe_valid),
      .out_item  (fe_item),
      .out_ready (fe_ready)
   );

   assign fe_ready = !q_full;

   // Decouple the front end from the passes.
   bpf_queue u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_valid),
      .push_item (fe_item),
      .full      (q_full),
      .pop       (chain_ready[0]),
      .pop_item  (chain_item[0]),
      .empty     (q_empty)
   );

   assign chain_valid[0] = !q_empty;

   // Cascade the passes; each advances a beat when the next one takes it.
   for (genvar s = 0; s < PASSES; s++) begin : g_pass
      bpf_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .csr_cfg   (csr_ff),
         .in_valid  (chain_valid[s]),
         .in_item   (chain_item[s]),
         .in_ready  (chain_ready[s]),
         .out_valid (chain_valid[s+1]),
         .out_item  (chain_item[s+1]),
         .out_ready (chain_ready[s+1])
      );
   end

   // Drop end markers; queue real results for the consumer.
   assign rq_push            = chain_valid[PASSES] && chain_item[PASSES].live && !rq_full;
   assign chain_ready[PASSES] = !chain_item[PASSES].live || !rq_full;

   bpf_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_item (chain_item[PASSES]),
      .full      (rq_full),
      .pop       (pop),
      .pop_item  (rq_head),
      .empty     (empty)
   );

   always_comb begin
      rsp_data.out_opcode   = rq_head.opcode;
      rsp_data.out_index    = rq_head.index;
      rsp_data.out_payload  = rq_head.payload;
      rsp_data.repeat_res   = rq_head.rep;
      rsp_data.run_overflow = rq_head.ovf;
      rsp_data.out_last     = rq_head.last;
   end

endmodule

// ----- hdl/bpf_queue.sv -----
// ---------------------------------------------------------------------------
// Beat queue
// Small first-in first-out buffer of beats between the parts of the filter.
// ---------------------------------------------------------------------------
module bpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bpf_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output bpf_pkg::item_type pop_item,
   output logic              empty
);
   import bpf_pkg::*;

   item_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == QUEUE_DEPTH[QUEUE_AW:0]);
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/bpf_front.sv -----
// ---------------------------------------------------------------------------
// Filter front end
// Accept instruction beats and tag them with their opcode class.
// ---------------------------------------------------------------------------
module bpf_front (
   input  logic              clock,
   input  logic              reset,
   input  bpf_pkg::csr_type  csr_cfg,
   input  logic              req_push,
   input  bpf_pkg::req_type  req_data,
   output logic              req_full,
   output logic              out_valid,
   output bpf_pkg::item_type out_item,
   input  logic              out_ready
);
   import bpf_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   item_type decoded;
   logic     accept;

   assign req_full  = valid_ff && !out_ready;
   assign accept    = req_push && !req_full;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      decoded.live    = 1'b1;
      decoded.opcode  = req_data.opcode;
      decoded.index   = req_data.local_index;
      decoded.payload = req_data.payload;
      decoded.rep     = 8'd1;
      decoded.ovf     = 1'b0;
      decoded.last    = req_data.last;
      decoded.cls     = classify(req_data.opcode, csr_cfg);

      if (accept) begin
         valid_in = 1'b1;
         item_in  = decoded;
      end else begin
         valid_in = valid_ff && !out_ready;
         item_in  = item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ----- hdl/bpf_stage.sv -----
// ---------------------------------------------------------------------------
// Peephole pass
// One pass of the rewrite rules: holds at most one pending instruction or
// Pop run and emits at most one beat per cycle into its output register.
// ---------------------------------------------------------------------------
module bpf_stage (
   input  logic              clock,
   input  logic              reset,
   input  bpf_pkg::csr_type  csr_cfg,
   input  logic              in_valid,
   input  bpf_pkg::item_type in_item,
   output logic              in_ready,
   output logic              out_valid,
   output bpf_pkg::item_type out_item,
   input  logic              out_ready
);
   import bpf_pkg::*;

   logic        held_valid_ff, held_valid_in;
   logic [7:0]  held_op_ff, held_op_in;
   logic [15:0] held_idx_ff, held_idx_in;
   logic [31:0] held_pay_ff, held_pay_in;
   logic [7:0]  held_pend_ff, held_pend_in;
   logic        held_ovf_ff, held_ovf_in;

   logic        out_valid_ff, out_valid_in;
   item_type    out_item_ff, out_item_in;

   logic        adv, consume, emit;
   logic        held_plain, held_run, cancel, merge;
   cls_type     held_cls;
   item_type    held_beat, run_beat, plain_beat, marker_beat, emit_beat;
   logic [7:0]  rep_eff;
   logic [8:0]  sum;

   assign adv       = !out_valid_ff || out_ready;
   assign in_ready  = consume;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   // Held item view and the merged Pop run.
   always_comb begin
      held_cls   = classify(held_op_ff, csr_cfg);
      held_plain = held_valid_ff && (held_pend_ff == '0);
      held_run   = held_valid_ff && (held_pend_ff != '0);
      cancel     = (held_cls.is_dup && in_item.cls.is_pop) ||
                   (held_cls.is_ld && in_item.cls.is_st && (held_idx_ff == in_item.index));

      held_beat.live    = 1'b1;
      held_beat.opcode  = held_op_ff;
      held_beat.index   = held_idx_ff;
      held_beat.payload = held_pay_ff;
      held_beat.rep     = held_run ? held_pend_ff : 8'd1;
      held_beat.ovf     = held_run && held_ovf_ff;
      held_beat.last    = 1'b0;
      held_beat.cls     = held_cls;

      marker_beat      = '0;
      marker_beat.last = 1'b1;

      plain_beat     = in_item;
      plain_beat.rep = 8'd1;
      plain_beat.ovf = 1'b0;

      // A Dup that eats one Pop of a run leaves the rest of the run.
      merge   = held_run;
      rep_eff = held_plain ? in_item.rep - 8'd1 : in_item.rep;
      sum     = {1'b0, merge ? held_pend_ff : 8'd0} + {1'b0, rep_eff};

      run_beat      = merge ? held_beat : in_item;
      run_beat.last = 1'b1;
      run_beat.ovf  = in_item.ovf || (merge && held_ovf_ff);
      if (sum == '0) begin
         run_beat.rep = 8'd1;
      end else if (sum > {1'b0, POP_CAP_B}) begin
         run_beat.rep = POP_CAP_B;
         run_beat.ovf = 1'b1;
      end else begin
         run_beat.rep = sum[7:0];
      end
   end

   // Rule selection.
   always_comb begin
      consume       = 1'b0;
      emit          = 1'b0;
      emit_beat     = held_beat;
      held_valid_in = held_valid_ff;
      held_op_in    = held_op_ff;
      held_idx_in   = held_idx_ff;
      held_pay_in   = held_pay_ff;
      held_pend_in  = held_pend_ff;
      held_ovf_in   = held_ovf_ff;

      if (adv && in_valid) begin
         priority if (!in_item.live) begin
            // end marker: flush what is held, else pass the marker on
            consume = 1'b1;
            if (held_valid_ff) begin
               emit           = 1'b1;
               emit_beat.last = 1'b1;
               held_valid_in  = 1'b0;
            end else if (in_item.last) begin
               emit      = 1'b1;
               emit_beat = in_item;
            end
         end else if ((held_plain && !cancel) ||
                      (held_run && !in_item.cls.is_pop && !in_item.cls.is_ret)) begin
            // send the held item out first; the new beat waits
            emit          = 1'b1;
            held_valid_in = 1'b0;
         end else if (held_plain && !(in_item.cls.is_pop && (in_item.rep > 8'd1))) begin
            // pair cancelled outright
            consume       = 1'b1;
            held_valid_in = 1'b0;
            if (in_item.last) begin
               emit      = 1'b1;
               emit_beat = marker_beat;
            end
         end else if (in_item.cls.is_pop) begin
            consume = 1'b1;
            if (in_item.last) begin
               emit          = 1'b1;
               emit_beat     = run_beat;
               held_valid_in = 1'b0;
            end else begin
               held_valid_in = 1'b1;
               held_op_in    = run_beat.opcode;
               held_idx_in   = run_beat.index;
               held_pay_in   = run_beat.payload;
               held_pend_in  = run_beat.rep;
               held_ovf_in   = run_beat.ovf;
            end
         end else begin
            // a Pop run before a Ret is dropped here
            consume       = 1'b1;
            held_valid_in = 1'b0;
            if ((in_item.cls.is_dup || in_item.cls.is_ld) && !in_item.last) begin
               held_valid_in = 1'b1;
               held_op_in    = in_item.opcode;
               held_idx_in   = in_item.index;
               held_pay_in   = in_item.payload;
               held_pend_in  = 8'd0;
               held_ovf_in   = 1'b0;
            end else begin
               emit      = 1'b1;
               emit_beat = plain_beat;
            end
         end
      end

      out_valid_in = adv ? emit : out_valid_ff;
      out_item_in  = adv ? emit_beat : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_op_ff   <= held_op_in;
      held_idx_ff  <= held_idx_in;
      held_pay_ff  <= held_pay_in;
      held_pend_ff <= held_pend_in;
      held_ovf_ff  <= held_ovf_in;
      out_item_ff  <= out_item_in;
   end

endmodule

// ----- bench/peephole_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Peephole filter checker
// Watches the instruction, result and register channels of the filter, runs
// its own cascade of reduction passes on every accepted instruction beat and
// compares each result beat, field by field, with the oldest kept instruction
// it predicted.
// ---------------------------------------------------------------------------
module peephole_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic             full,
   input  bpf_pkg::req_type req_data,
   input  logic             empty,
   input  logic             pop,
   input  bpf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_data,
   output int               mismatches,
   output int               expected_left
);
   import bpf_pkg::*;

   localparam csr_type RESET_CODES = '{pop_code: 8'd0, dup_code: 8'd1, load_local_code: 8'd2,
                                       store_local_code: 8'd3, return_code: 8'd4};

   // One instruction moving between passes; live=0 is a bare end marker.
   typedef struct {
      bit          live;
      logic [7:0]  op;
      logic [15:0] idx;
      logic [31:0] pay;
      int unsigned rep;
      bit          sat;
      bit          last;
   } instr_type;

   csr_type     codes;
   bit          held_v    [PASSES];
   logic [7:0]  held_op   [PASSES];
   logic [15:0] held_ix   [PASSES];
   logic [31:0] held_pl   [PASSES];
   logic [7:0]  held_runs [PASSES];
   bit          held_sat  [PASSES];

   instr_type   stage_out[$];
   rsp_type     kept_instrs[$];
   int          fail_count = 0;
   int          shown = 0;

   function automatic instr_type end_mark();
      instr_type m;
      m = '{default: 0};
      m.last = 1'b1;
      return m;
   endfunction

   function automatic instr_type held_instr(int s, bit lst);
      instr_type h;
      h.live = 1'b1;
      h.op   = held_op[s];
      h.idx  = held_ix[s];
      h.pay  = held_pl[s];
      h.rep  = (held_runs[s] != 0) ? held_runs[s] : 1;
      h.sat  = (held_runs[s] != 0) ? held_sat[s] : 1'b0;
      h.last = lst;
      return h;
   endfunction

   function automatic void drop_held(int s);
      held_v[s]    = 1'b0;
      held_op[s]   = '0;
      held_ix[s]   = '0;
      held_pl[s]   = '0;
      held_runs[s] = '0;
      held_sat[s]  = 1'b0;
   endfunction

   // One pass of the cascade: consume one instruction, append what leaves.
   function automatic void reduce_stage(int s, instr_type cur);
      int unsigned sum;
      bit          sat;
      bit          cancel;
      if (!cur.live) begin
         if (held_v[s]) begin
            stage_out = {stage_out, held_instr(s, 1'b1)};
            drop_held(s);
         end else if (cur.last) begin
            stage_out = {stage_out, end_mark()};
         end
         return;
      end
      // a held Dup or LdLoc meets its successor
      if (held_v[s] && held_runs[s] == 0) begin
         cancel = (held_op[s] == codes.dup_code && cur.op == codes.pop_code) ||
                  (held_op[s] == codes.load_local_code && cur.op == codes.store_local_code &&
                   held_ix[s] == cur.idx);
         if (cancel) begin
            drop_held(s);
            if (cur.op == codes.pop_code && cur.rep > 1) begin
               cur.rep = cur.rep - 1;
            end else begin
               if (cur.last) stage_out = {stage_out, end_mark()};
               return;
            end
         end else begin
            stage_out = {stage_out, held_instr(s, 1'b0)};
            drop_held(s);
         end
      end
      // merge Pops into the held run
      if (cur.op == codes.pop_code) begin
         sat = cur.sat;
         if (held_v[s]) begin
            sum = held_runs[s] + cur.rep;
            sat = sat | held_sat[s];
         end else begin
            sum        = cur.rep;
            held_v[s]  = 1'b1;
            held_op[s] = cur.op;
            held_ix[s] = cur.idx;
            held_pl[s] = cur.pay;
         end
         if (sum < 1) sum = 1;
         if (sum > POP_CAP) begin
            sum = POP_CAP;
            sat = 1'b1;
         end
         held_runs[s] = sum[7:0];
         held_sat[s]  = sat;
         if (cur.last) begin
            stage_out = {stage_out, held_instr(s, 1'b1)};
            drop_held(s);
         end
         return;
      end
      // a Pop run ends here; drop it before Ret
      if (held_v[s]) begin
         if (cur.op != codes.return_code) stage_out = {stage_out, held_instr(s, 1'b0)};
         drop_held(s);
      end
      if ((cur.op == codes.dup_code || cur.op == codes.load_local_code) && !cur.last) begin
         held_v[s]    = 1'b1;
         held_op[s]   = cur.op;
         held_ix[s]   = cur.idx;
         held_pl[s]   = cur.pay;
         held_runs[s] = '0;
         held_sat[s]  = 1'b0;
         return;
      end
      cur.rep = 1;
      cur.sat = 1'b0;
      stage_out = {stage_out, cur};
   endfunction

   always @(posedge clock) begin : watch
      instr_type flow[$];
      instr_type head;
      rsp_type   want;
      bit        bad;
      if (reset) begin
         for (int s = 0; s < PASSES; s++) drop_held(s);
         codes = RESET_CODES;
         kept_instrs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_POP_CODE:         codes.pop_code         = csr_data;
               CSR_DUP_CODE:         codes.dup_code         = csr_data;
               CSR_LOAD_LOCAL_CODE:  codes.load_local_code  = csr_data;
               CSR_STORE_LOCAL_CODE: codes.store_local_code = csr_data;
               CSR_RETURN_CODE:      codes.return_code      = csr_data;
               default: ;
            endcase
         end
         if (push && !full) begin
            head.live = 1'b1;
            head.op   = req_data.opcode;
            head.idx  = req_data.local_index;
            head.pay  = req_data.payload;
            head.rep  = 1;
            head.sat  = 1'b0;
            head.last = req_data.last;
            flow.delete();
            flow = {flow, head};
            for (int s = 0; s < PASSES; s++) begin
               stage_out.delete();
               foreach (flow[i]) reduce_stage(s, flow[i]);
               flow = stage_out;
            end
            foreach (flow[i]) begin
               if (flow[i].live) begin
                  want.out_opcode   = flow[i].op;
                  want.out_index    = flow[i].idx;
                  want.out_payload  = flow[i].pay;
                  want.repeat_res   = flow[i].rep[7:0];
                  want.run_overflow = flow[i].sat;
                  want.out_last     = flow[i].last;
                  kept_instrs = {kept_instrs, want};
               end
            end
         end
         if (pop && !empty) begin
            if (kept_instrs.size() == 0) begin
               fail_count++;
               if (shown < 10) begin
                  shown++;
                  $display("%0t: unexpected result op %h idx %h pay %h rep %0d ovf %b last %b",
                           $realtime, rsp_data.out_opcode, rsp_data.out_index,
                           rsp_data.out_payload, rsp_data.repeat_res, rsp_data.run_overflow,
                           rsp_data.out_last);
               end
            end else begin
               want = kept_instrs.pop_front();
               bad = (rsp_data.out_opcode   !== want.out_opcode)   ||
                     (rsp_data.out_index    !== want.out_index)    ||
                     (rsp_data.out_payload  !== want.out_payload)  ||
                     (rsp_data.repeat_res   !== want.repeat_res)   ||
                     (rsp_data.run_overflow !== want.run_overflow) ||
                     (rsp_data.out_last     !== want.out_last);
               if (bad) begin
                  fail_count++;
                  if (shown < 10) begin
                     shown++;
                     $display({"%0t: mismatch exp op %h idx %h pay %h rep %0d ovf %b last %b",
                               " / got op %h idx %h pay %h rep %0d ovf %b last %b"},
                              $realtime, want.out_opcode, want.out_index, want.out_payload,
                              want.repeat_res, want.run_overflow, want.out_last,
                              rsp_data.out_opcode, rsp_data.out_index, rsp_data.out_payload,
                              rsp_data.repeat_res, rsp_data.run_overflow, rsp_data.out_last);
                  end
               end
            end
         end
      end
      expected_left <= kept_instrs.size();
      mismatches    <= fail_count;
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Peephole filter testbench
// Drives instruction beats into the filter in whole methods, programs the
// opcode registers between phases and stalls both channels at random; the
// checker beside the filter predicts and compares every result beat.
// ---------------------------------------------------------------------------
module testbench;
   import bpf_pkg::*;

   localparam int         STALL_LIMIT  = 1000;                 // cycles with no beat moving
   localparam int         SETTLE       = 3 * (PASSES + 4) + 8; // quiet cycles after draining
   localparam int         PHASE_ITEMS  = 10;
   localparam int         PHASES       = 7;
   localparam int         SAT_RUN      = 260;                  // longer than any run count
   localparam logic [7:0] NOP_OP       = 8'hFF;                // matches no default code

   localparam csr_type DEFAULT_CODES = '{pop_code: 8'd0, dup_code: 8'd1, load_local_code: 8'd2,
                                         store_local_code: 8'd3, return_code: 8'd4};

   logic       clock;
   logic       reset     = 1'b1;
   logic       push      = 1'b0;
   req_type    req_data  = '0;
   logic       full;
   logic       empty;
   logic       pop       = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_data  = '0;

   int         mismatches;
   int         expected_left;
   int         idle_cycles = 0;
   int         items_sent  = 0;
   bit         calm        = 1'b0;   // no idling on either side
   csr_type    codes       = DEFAULT_CODES;

   bytecode_peephole_filter u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   peephole_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run if no beat moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Result side: hold pop high and drop it low in alternating random stretches.
   initial begin
      forever begin
         if (calm) begin
            pop <= 1'b1;
            @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 12)) @(posedge clock);
            if (!calm) begin
               pop <= 1'b0;
               repeat ($urandom_range(1, 7)) @(posedge clock);
            end
         end
      end
   end

   function automatic req_type mk(logic [7:0] op, logic [15:0] ix, logic [31:0] pay,
                                  logic lst);
      req_type r;
      r.opcode      = op;
      r.local_index = ix;
      r.payload     = pay;
      r.last        = lst;
      return r;
   endfunction

   function automatic req_type op_beat(logic [7:0] op, logic [15:0] ix);
      return mk(op, ix, $urandom(), 1'b0);
   endfunction

   // Mostly a few local numbers, so that LdLoc/StLoc pairs meet.
   function automatic logic [15:0] pick_ix();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 4))
         0:       return codes.pop_code;
         1:       return codes.dup_code;
         2:       return codes.load_local_code;
         3:       return codes.store_local_code;
         default: return codes.return_code;
      endcase
   endfunction

   // Move one instruction beat, with an occasional gap in front of it.
   task automatic send_instr(input req_type r);
      if (!calm && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   // Write all five opcode registers back to back; call only while idle.
   task automatic load_codes(input csr_type c);
      csr_index_type slot [5];
      logic [7:0]    val  [5];
      slot = '{CSR_POP_CODE, CSR_DUP_CODE, CSR_LOAD_LOCAL_CODE, CSR_STORE_LOCAL_CODE,
               CSR_RETURN_CODE};
      val  = '{c.pop_code, c.dup_code, c.load_local_code, c.store_local_code, c.return_code};
      csr_valid <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= slot[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      codes = c;
   endtask

   // Stop sending, wait for every predicted result, then let the passes settle.
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Build one method from random peephole patterns and noise; end it with last.
   task automatic send_method();
      req_type     seq[$];
      logic [15:0] ix;
      int unsigned n;
      repeat ($urandom_range(1, 5)) begin
         ix = pick_ix();
         n  = $urandom_range(1, 5);
         case ($urandom_range(0, 9))
            0: begin   // Pop run dropped before Ret
               repeat (n) seq = {seq, op_beat(codes.pop_code, pick_ix())};
               seq = {seq, op_beat(codes.return_code, pick_ix())};
            end
            1: repeat (n) seq = {seq, op_beat(codes.pop_code, pick_ix())};
            2: begin   // Dup eats the head of a run
               seq = {seq, op_beat(codes.dup_code, pick_ix())};
               repeat (n) seq = {seq, op_beat(codes.pop_code, pick_ix())};
            end
            3: begin
               seq = {seq, op_beat(codes.load_local_code, ix)};
               seq = {seq, op_beat(codes.store_local_code, ix)};
            end
            4: begin   // locals differ in one bit
               seq = {seq, op_beat(codes.load_local_code, ix)};
               seq = {seq, op_beat(codes.store_local_code,
                                   ix ^ (16'd1 << $urandom_range(0, 15)))};
            end
            5: begin   // nested pair, cancelled by the second pass
               seq = {seq, op_beat(codes.dup_code, pick_ix())};
               seq = {seq, op_beat(codes.dup_code, pick_ix())};
               seq = {seq, op_beat(codes.pop_code, pick_ix())};
               seq = {seq, op_beat(codes.pop_code, pick_ix())};
            end
            6: begin
               seq = {seq, op_beat(codes.load_local_code, ix)};
               seq = {seq, op_beat(codes.dup_code, pick_ix())};
               seq = {seq, op_beat(codes.pop_code, pick_ix())};
               seq = {seq, op_beat(codes.store_local_code, ix)};
            end
            7: seq = {seq, op_beat(pick_code(), pick_ix())};
            8: seq = {seq, op_beat(8'($urandom()), 16'($urandom()))};
            default: begin   // broken pair
               seq = {seq, op_beat($urandom_range(0, 1) ? codes.dup_code
                                                        : codes.load_local_code, ix)};
               seq = {seq, op_beat($urandom_range(0, 1) ? codes.return_code
                                                        : 8'($urandom()), pick_ix())};
            end
         endcase
      end
      // split into several methods now and then
      foreach (seq[i]) if ($urandom_range(0, 15) == 0) seq[i].last = 1'b1;
      seq[seq.size() - 1].last = 1'b1;
      foreach (seq[i]) send_instr(seq[i]);
   endtask

   initial begin : stimulus
      csr_type cfg;
      int      goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and each rewrite rule under the default codes.
      load_codes(DEFAULT_CODES);
      send_instr(mk(NOP_OP, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
      send_instr(op_beat(codes.pop_code, 16'h0001));
      send_instr(op_beat(codes.pop_code, 16'h0002));
      send_instr(op_beat(codes.pop_code, 16'h0003));
      send_instr(op_beat(codes.return_code, 16'h0004));          // run dropped, Ret kept
      send_instr(op_beat(codes.dup_code, 16'h0000));
      send_instr(op_beat(codes.pop_code, 16'h0000));             // Dup/Pop cancel
      send_instr(op_beat(codes.load_local_code, 16'd5));
      send_instr(op_beat(codes.store_local_code, 16'd5));        // LdLoc/StLoc cancel
      send_instr(op_beat(codes.load_local_code, 16'hFFFF));
      send_instr(op_beat(codes.store_local_code, 16'hFFFE));     // locals differ: keep both
      send_instr(op_beat(codes.dup_code, 16'd0));
      send_instr(op_beat(codes.dup_code, 16'd0));
      send_instr(op_beat(codes.pop_code, 16'd0));
      send_instr(op_beat(codes.pop_code, 16'd0));                // cancelled across passes
      send_instr(mk(codes.pop_code, 16'h8000, 32'hFFFF_FFFF, 1'b0));
      send_instr(mk(codes.pop_code, 16'h7FFF, 32'h0000_0000, 1'b0));
      send_instr(mk(NOP_OP, 16'd0, 32'h8000_0001, 1'b1));        // run of two, then method end
      send_instr(op_beat(codes.load_local_code, 16'd7));
      send_instr(mk(codes.store_local_code, 16'd7, 32'h0, 1'b1)); // final beat vanishes
      send_instr(mk(codes.pop_code, 16'd0, 32'h0, 1'b1));        // lone Pop ends the method
      send_instr(mk(codes.dup_code, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      drain();

      // Random methods under several code settings; drain before each rewrite.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            1:       cfg = '{8'd255, 8'd0, 8'd254, 8'd1, 8'd128};  // extreme codes
            2:       cfg = '{8'd9, 8'd9, 8'd10, 8'd11, 8'd9};      // Pop shadows Dup and Ret
            3:       cfg = '{8'd20, 8'd21, 8'd21, 8'd22, 8'd23};   // Dup and LdLoc share a code
            4:       cfg = '{8'd30, 8'd31, 8'd32, 8'd32, 8'd33};   // LdLoc and StLoc share a code
            5:       cfg = '{8'($urandom()), 8'($urandom()), 8'($urandom()),
                             8'($urandom()), 8'($urandom())};
            default: cfg = DEFAULT_CODES;
         endcase
         load_codes(cfg);
         if (ph == PHASES - 1) calm = 1'b1;   // last stretch runs at full rate
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) send_method();
         if (ph == 0) begin
            // push a Pop run past the count limit so the overflow flag rises
            repeat (SAT_RUN - 1) send_instr(op_beat(codes.pop_code, pick_ix()));
            send_instr(mk(NOP_OP, pick_ix(), $urandom(), 1'b1));
         end
         drain();
      end

      if (mismatches == 0 && expected_left == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- bytecode_peephole_filter.f -----
hdl/bpf_pkg.sv
hdl/bpf_queue.sv
hdl/bpf_front.sv
hdl/bpf_stage.sv
hdl/bytecode_peephole_filter.sv
bench/peephole_checker.sv
bench/testbench.sv
